>>> hw/rtl/position_pid_controller_defines.svh
// assertion macros for the position pid controller checker
// depends on clk_i and rst_ni being visible where a macro is used
`ifndef POSITION_PID_CONTROLLER_DEFINES_SVH
`define POSITION_PID_CONTROLLER_DEFINES_SVH

// checked only outside reset
`define PPID_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define PPID_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hw/rtl/pospid_pkg.sv
// shared types and constants for the position pid controller
// no dependencies
package pospid_pkg;

  localparam int PosW     = 16;
  localparam int GainW    = 16;
  localparam int ErrW     = PosW + 1;
  localparam int SumW     = 9;
  localparam int DerrW    = ErrW + 1;
  localparam int DriveW   = 9;
  localparam int FracBits = 8;

  localparam int ProdPW  = GainW + ErrW;
  localparam int ProdIW  = GainW + SumW;
  localparam int ProdDW  = GainW + DerrW;
  localparam int TotalW  = ProdDW + 2;
  localparam int ShiftW  = TotalW - FracBits;

  localparam int SumLimit   = 200;
  localparam int DriveLimit = 200;

  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam int CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GAIN_P = 2'd0,
    REG_GAIN_I = 2'd1,
    REG_GAIN_D = 2'd2
  } cfg_reg_e;

  localparam logic signed [GainW-1:0] GainPReset = -16'sd77;
  localparam logic signed [GainW-1:0] GainIReset = -16'sd8;
  localparam logic signed [GainW-1:0] GainDReset = 16'sd0;

  typedef struct packed {
    logic signed [GainW-1:0] p;
    logic signed [GainW-1:0] i;
    logic signed [GainW-1:0] d;
  } gains_t;

  typedef struct packed {
    logic signed [ErrW-1:0]  err;
    logic signed [SumW-1:0]  sum;
    logic signed [DerrW-1:0] derr;
  } work_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } qctl_t;

endpackage

>>> hw/rtl/pospid_queue.sv
// two-entry queue of prepared terms between front and back
// depends on pospid_pkg
module pospid_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pospid_pkg::work_t  push_data_i,
  input  logic               pop_i,
  output pospid_pkg::work_t  pop_data_o,
  output logic               full_o,
  output logic               empty_o
);

  pospid_pkg::work_t                 mem_q [pospid_pkg::QueueDepth];
  logic [pospid_pkg::QPtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [pospid_pkg::QPtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [pospid_pkg::QCntW-1:0]      count_q, count_d;

  assign full_o     = (count_q == pospid_pkg::QCntW'(pospid_pkg::QueueDepth));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == pospid_pkg::QPtrW'(pospid_pkg::QueueDepth - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == pospid_pkg::QPtrW'(pospid_pkg::QueueDepth - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> hw/rtl/pospid_front.sv
// front end: takes requests, forms error, clamped sum and error delta
// depends on pospid_pkg
module pospid_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [pospid_pkg::PosW-1:0]      target_pos_i,
  input  logic [pospid_pkg::PosW-1:0]      measured_pos_i,
  input  pospid_pkg::qctl_t                qctl_i,
  output logic                             push_o,
  output pospid_pkg::work_t                work_o
);

  logic signed [pospid_pkg::SumW-1:0]  error_sum_q, error_sum_d;
  logic signed [pospid_pkg::ErrW-1:0]  prior_error_q, prior_error_d;
  logic signed [pospid_pkg::ErrW-1:0]  err;
  logic signed [pospid_pkg::SumW+pospid_pkg::ErrW-1:0] sum_full;
  logic                                accept;

  assign in_ready_o = !qctl_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept;

  always_comb begin
    err = $signed({1'b0, target_pos_i}) - $signed({1'b0, measured_pos_i});
    sum_full = (pospid_pkg::SumW+pospid_pkg::ErrW)'(error_sum_q)
             + (pospid_pkg::SumW+pospid_pkg::ErrW)'(err);
    if (sum_full > pospid_pkg::SumLimit) begin
      error_sum_d = pospid_pkg::SumW'(pospid_pkg::SumLimit);
    end else if (sum_full < -pospid_pkg::SumLimit) begin
      error_sum_d = pospid_pkg::SumW'(-pospid_pkg::SumLimit);
    end else begin
      error_sum_d = pospid_pkg::SumW'(sum_full);
    end
    prior_error_d = err;
    work_o.err  = err;
    work_o.sum  = error_sum_d;
    work_o.derr = pospid_pkg::DerrW'(err) - pospid_pkg::DerrW'(prior_error_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      error_sum_q   <= '0;
      prior_error_q <= '0;
    end else if (accept) begin
      error_sum_q   <= error_sum_d;
      prior_error_q <= prior_error_d;
    end
  end

endmodule

>>> hw/rtl/pospid_back.sv
// back end: gain products, then sum, floor shift and clamp into the output register
// depends on pospid_pkg
module pospid_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pospid_pkg::gains_t                  gains_i,
  input  pospid_pkg::qctl_t                   qctl_i,
  input  pospid_pkg::work_t                   work_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [pospid_pkg::DriveW-1:0] drive_o
);

  logic                                       prod_valid_q;
  logic signed [pospid_pkg::ProdPW-1:0]       prod_p_q, prod_p_d;
  logic signed [pospid_pkg::ProdIW-1:0]       prod_i_q, prod_i_d;
  logic signed [pospid_pkg::ProdDW-1:0]       prod_d_q, prod_d_d;
  logic                                       out_valid_q;
  logic signed [pospid_pkg::DriveW-1:0]       drive_q, drive_d;
  logic signed [pospid_pkg::TotalW-1:0]       total;
  logic signed [pospid_pkg::ShiftW-1:0]       shifted;
  logic                                       out_en;
  logic                                       prod_en;

  assign out_en  = !out_valid_q || out_ready_i;
  assign prod_en = !prod_valid_q || out_en;
  assign pop_o   = prod_en && !qctl_i.empty;

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;

  always_comb begin
    prod_p_d = pospid_pkg::ProdPW'(gains_i.p) * pospid_pkg::ProdPW'(work_i.err);
    prod_i_d = pospid_pkg::ProdIW'(gains_i.i) * pospid_pkg::ProdIW'(work_i.sum);
    prod_d_d = pospid_pkg::ProdDW'(gains_i.d) * pospid_pkg::ProdDW'(work_i.derr);
  end

  always_comb begin
    total = pospid_pkg::TotalW'(prod_p_q) + pospid_pkg::TotalW'(prod_i_q)
          + pospid_pkg::TotalW'(prod_d_q);
    shifted = total[pospid_pkg::TotalW-1:pospid_pkg::FracBits];
    if (shifted > pospid_pkg::DriveLimit) begin
      drive_d = pospid_pkg::DriveW'(pospid_pkg::DriveLimit);
    end else if (shifted < -pospid_pkg::DriveLimit) begin
      drive_d = pospid_pkg::DriveW'(-pospid_pkg::DriveLimit);
    end else begin
      drive_d = pospid_pkg::DriveW'(shifted);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (prod_en) begin
        prod_valid_q <= !qctl_i.empty;
      end
      if (out_en) begin
        out_valid_q <= prod_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      prod_p_q <= prod_p_d;
      prod_i_q <= prod_i_d;
      prod_d_q <= prod_d_d;
    end
    if (out_en && prod_valid_q) begin
      drive_q <= drive_d;
    end
  end

endmodule

>>> hw/rtl/position_pid_controller.sv
// position pid controller top level: gain registers, front, queue and back
// a taken request passes the queue, then the product and the output registers
// throughput one request per cycle unless stalled; the multiply and sum/clamp
// stages of the back end each hold one item; the two-entry queue absorbs stalls
// reset clears the error sum, the previous error and all valid state and
// loads the gains with their default values
module position_pid_controller (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [pospid_pkg::PosW-1:0]          target_pos_i,
  input  logic [pospid_pkg::PosW-1:0]          measured_pos_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [pospid_pkg::DriveW-1:0] drive_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [pospid_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [pospid_pkg::GainW-1:0]         cfg_data_i
);

  pospid_pkg::gains_t gains_q, gains_d;
  pospid_pkg::qctl_t  qctl;
  pospid_pkg::work_t  push_data;
  pospid_pkg::work_t  pop_data;
  logic               push;
  logic               pop;
  logic               full;
  logic               empty;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    gains_d = gains_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        pospid_pkg::REG_GAIN_P: gains_d.p = $signed(cfg_data_i);
        pospid_pkg::REG_GAIN_I: gains_d.i = $signed(cfg_data_i);
        pospid_pkg::REG_GAIN_D: gains_d.d = $signed(cfg_data_i);
        default:                gains_d   = gains_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q.p <= pospid_pkg::GainPReset;
      gains_q.i <= pospid_pkg::GainIReset;
      gains_q.d <= pospid_pkg::GainDReset;
    end else begin
      gains_q <= gains_d;
    end
  end

  always_comb begin
    qctl.push  = push;
    qctl.pop   = pop;
    qctl.full  = full;
    qctl.empty = empty;
  end

  pospid_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .target_pos_i   (target_pos_i),
    .measured_pos_i (measured_pos_i),
    .qctl_i         (qctl),
    .push_o         (push),
    .work_o         (push_data)
  );

  pospid_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .full_o      (full),
    .empty_o     (empty)
  );

  pospid_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .gains_i     (gains_q),
    .qctl_i      (qctl),
    .work_i      (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .drive_o     (drive_o)
  );

endmodule

>>> hw/rtl/pospid_checker.sv
// port-level checks for the position pid controller, bound to the top level
// depends on pospid_pkg and position_pid_controller_defines.svh
`include "position_pid_controller_defines.svh"

module pospid_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_o,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic signed [pospid_pkg::DriveW-1:0] drive_o
);

  logic in_accept;
  logic out_stall;
  logic drive_in_range;

  assign in_accept      = in_valid_i && in_ready_o;
  assign out_stall      = out_valid_o && !out_ready_i;
  assign drive_in_range = (drive_o <= pospid_pkg::DriveLimit) &&
                          (drive_o >= -pospid_pkg::DriveLimit);

  // no result after a reset edge
  `PPID_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |=> !out_valid_o, "result valid in reset")

  // drive stays within its clamp
  `PPID_ASSERT(a_drive_range, out_valid_o |-> drive_in_range, "drive out of range")

  // a result after an empty output comes from a taken request that went through the queue, product and output registers
  `PPID_ASSERT(a_out_latency, $rose(out_valid_o) |-> $past(in_accept, 3), "result without request")

  // a stalled result holds
  `PPID_ASSERT(a_out_hold, out_stall |=> out_valid_o && $stable(drive_o), "stalled result changed")

endmodule

bind position_pid_controller pospid_checker u_checker (.*);
